// File: sv/pssp_pkg.sv
// ----------------------------------------------------------------------------
// pssp_pkg
// Types and constants for the custom paper size string parser.
// ----------------------------------------------------------------------------
`default_nettype none

package pssp_pkg;

    // Field widths
    localparam int CHAR_W   = 8;
    localparam int SIZE_W   = 22;
    // Two sizes packed, padded to whole bytes
    localparam int M_DATA_W = ((2 * SIZE_W + 7) / 8) * 8;
    // Room for acc * 10 + 9 with acc at the limit
    localparam int MUL_W    = SIZE_W + 4;

    localparam logic [SIZE_W-1:0] SIZE_LIMIT = SIZE_W'(32767 * 100);

    localparam int              PREFIX_LEN = 7;
    localparam logic [2:0]      PREFIX_END = 3'(PREFIX_LEN);

    localparam logic [CHAR_W-1:0] CHAR_X    = 8'h78; // 'x'
    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30; // '0'
    localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39; // '9'

    // Expected byte of "custom:" at each position
    function automatic logic [CHAR_W-1:0] prefix_byte(input logic [2:0] pos);
        logic [CHAR_W-1:0] b;
        case (pos)
            3'd0:    b = 8'h63; // c
            3'd1:    b = 8'h75; // u
            3'd2:    b = 8'h73; // s
            3'd3:    b = 8'h74; // t
            3'd4:    b = 8'h6F; // o
            3'd5:    b = 8'h6D; // m
            3'd6:    b = 8'h3A; // :
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// File: sv/paper_size_string_parser_core.sv
// ----------------------------------------------------------------------------
// paper_size_string_parser_core
// Parses "custom:<W>x<H>" one byte per word and reports width and height.
// ----------------------------------------------------------------------------
// The result word is registered: it shows in the cycle after the last byte.
// Throughput: one byte per cycle unless input is held off as below; the
//   parse state and x10 add sit between state and result registers.
// Input is held off only while a result word waits and the sink stalls.
// Reset (i_rst_n low, synchronous) returns to the prefix phase and drops
//   any pending result.
`default_nettype none

module paper_size_string_parser_core (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // Slave side
    input  wire                              i_s_tvalid,
    output logic                             o_s_tready,
    input  wire  [pssp_pkg::CHAR_W-1:0]      i_s_tdata,  // [7:0] char_byte
    input  wire                              i_s_tlast,  // end_of_string
    // Master side
    output logic                             o_m_tvalid,
    input  wire                              i_m_tready,
    output logic [pssp_pkg::M_DATA_W-1:0]    o_m_tdata,  // [21:0] width_um,
                                                         // [43:22] height_um,
                                                         // [47:44] zero
    output logic                             o_m_tuser   // is_valid
);

    localparam int SW = pssp_pkg::SIZE_W;
    localparam int MW = pssp_pkg::MUL_W;

    typedef enum logic [1:0] {
        PH_PREFIX = 2'd0,
        PH_WIDTH  = 2'd1,
        PH_HEIGHT = 2'd2
    } t_phase;

    // Parse state
    t_phase           r_phase, n_phase;
    logic [2:0]       r_pos, n_pos;
    logic [SW-1:0]    r_w_acc, n_w_acc;
    logic [SW-1:0]    r_h_acc, n_h_acc;
    logic             r_w_seen, n_w_seen;
    logic             r_h_seen, n_h_seen;
    logic             r_fail, n_fail;

    // Result register
    logic                          r_m_valid;
    logic [pssp_pkg::M_DATA_W-1:0] r_m_data;
    logic                          r_m_user;

    logic          accept;
    logic          is_digit;
    logic [3:0]    digit;
    logic [SW-1:0] acc_sel;
    logic [MW-1:0] acc_next;
    logic          acc_over;
    logic          ok;

    // Skid-free: a waiting result blocks input only if the sink stalls
    assign o_s_tready = !r_m_valid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;

    assign is_digit = (i_s_tdata >= pssp_pkg::CHAR_ZERO) &&
                      (i_s_tdata <= pssp_pkg::CHAR_NINE);
    assign digit    = 4'(i_s_tdata - pssp_pkg::CHAR_ZERO);

    // One shared x10 + digit; only the active number is fed through
    assign acc_sel  = (r_phase == PH_WIDTH) ? r_w_acc : r_h_acc;
    assign acc_next = {1'b0, acc_sel, 3'b000} + {3'b000, acc_sel, 1'b0} + MW'(digit);
    assign acc_over = acc_next > MW'(pssp_pkg::SIZE_LIMIT);

    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_w_acc  = r_w_acc;
        n_h_acc  = r_h_acc;
        n_w_seen = r_w_seen;
        n_h_seen = r_h_seen;
        n_fail   = r_fail;
        if (!r_fail) begin
            case (r_phase)
                PH_PREFIX: begin
                    if (r_pos < pssp_pkg::PREFIX_END &&
                        i_s_tdata == pssp_pkg::prefix_byte(r_pos)) begin
                        n_pos = r_pos + 3'd1;
                        if (n_pos == pssp_pkg::PREFIX_END) begin
                            n_phase = PH_WIDTH;
                        end
                    end else begin
                        n_fail = 1'b1;
                    end
                end
                PH_WIDTH: begin
                    if (i_s_tdata == pssp_pkg::CHAR_X) begin
                        n_phase = PH_HEIGHT;
                    end else if (is_digit) begin
                        n_w_seen = 1'b1;
                        if (acc_over) begin
                            n_fail = 1'b1;   // sticky; accumulator keeps value
                        end else begin
                            n_w_acc = acc_next[SW-1:0];
                        end
                    end else begin
                        n_fail = 1'b1;
                    end
                end
                PH_HEIGHT: begin
                    if (is_digit) begin
                        n_h_seen = 1'b1;
                        if (acc_over) begin
                            n_fail = 1'b1;
                        end else begin
                            n_h_acc = acc_next[SW-1:0];
                        end
                    end else begin
                        n_fail = 1'b1;   // second 'x' lands here too
                    end
                end
                default: n_fail = 1'b1;
            endcase
        end
    end

    // Verdict on the updated state, used on the end-marked byte
    assign ok = !n_fail && (n_phase == PH_HEIGHT) &&
                n_w_seen && n_h_seen &&
                (n_w_acc != '0) && (n_h_acc != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_PREFIX;
            r_pos     <= 3'd0;
            r_w_acc   <= '0;
            r_h_acc   <= '0;
            r_w_seen  <= 1'b0;
            r_h_seen  <= 1'b0;
            r_fail    <= 1'b0;
            r_m_valid <= 1'b0;
            r_m_user  <= 1'b0;
            r_m_data  <= '0;
        end else begin
            if (accept) begin
                if (i_s_tlast) begin
                    // String done: back to the prefix phase for the next one
                    r_phase  <= PH_PREFIX;
                    r_pos    <= 3'd0;
                    r_w_acc  <= '0;
                    r_h_acc  <= '0;
                    r_w_seen <= 1'b0;
                    r_h_seen <= 1'b0;
                    r_fail   <= 1'b0;
                end else begin
                    r_phase  <= n_phase;
                    r_pos    <= n_pos;
                    r_w_acc  <= n_w_acc;
                    r_h_acc  <= n_h_acc;
                    r_w_seen <= n_w_seen;
                    r_h_seen <= n_h_seen;
                    r_fail   <= n_fail;
                end
            end
            if (accept && i_s_tlast) begin
                r_m_valid <= 1'b1;
                r_m_user  <= ok;
                r_m_data  <= ok ? pssp_pkg::M_DATA_W'({n_h_acc, n_w_acc}) : '0;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;

endmodule

`default_nettype wire

// File: sv/pssp_checker.sv
// ----------------------------------------------------------------------------
// pssp_checker
// Port-level checks on the paper size string parser.
// ----------------------------------------------------------------------------
`default_nettype none

module pssp_checker (
    input wire                           i_clk,
    input wire                           i_rst_n,
    input wire                           i_s_tvalid,
    input wire                           o_s_tready,
    input wire                           i_s_tlast,
    input wire                           o_m_tvalid,
    input wire                           i_m_tready,
    input wire [pssp_pkg::M_DATA_W-1:0]  o_m_tdata,
    input wire                           o_m_tuser
);

    localparam int SW = pssp_pkg::SIZE_W;

    // Stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result word changed while stalled");

    // Failed string reports zero sizes
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata == '0)
        else $error("invalid result with non-zero sizes");

    // Legal string: both sizes non-zero and within the limit, padding clear
    a_ok_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |->
            o_m_tdata[SW-1:0] != '0 && o_m_tdata[2*SW-1:SW] != '0 &&
            o_m_tdata[SW-1:0] <= pssp_pkg::SIZE_LIMIT &&
            o_m_tdata[2*SW-1:SW] <= pssp_pkg::SIZE_LIMIT &&
            o_m_tdata[pssp_pkg::M_DATA_W-1:2*SW] == '0)
        else $error("valid result out of range");

    // A byte that is not the last one produces no result
    a_no_mid_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && !i_s_tlast && !(o_m_tvalid && !i_m_tready)
            |=> !o_m_tvalid)
        else $error("result word without end-marked byte");

endmodule

bind paper_size_string_parser_core pssp_checker u_pssp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tlast  (i_s_tlast),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

`default_nettype wire
